// File: rtl/afjb_pkg.sv
// afjb_pkg: shared types, request codes and defaults for the audio frame jitter buffer.
// Depends on nothing; used by afjb_out_queue and audio_frame_jitter_buffer.
`default_nettype none

package afjb_pkg;

    // Parameter defaults
    localparam int BUFFER_FRAMES_DEF    = 16384;
    localparam int MAX_PRIME_FRAMES_DEF = 4096;

    // Register reset values
    localparam logic [14:0] CAP_RESET    = 15'd16384;
    localparam logic        STEREO_RESET = 1'b1;
    localparam logic [12:0] PRIME_RESET  = 13'd2048;

    // Register indexes on the APB port (byte address = 4 * index)
    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_STEREO   = 2'd1;
    localparam logic [1:0] REG_PRIME    = 2'd2;

    // Request codes carried on s_tuser; code 3 means nothing and is ignored
    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_RESET = 2'd2
    } req_t;

    // One result word
    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic               underrun;
        logic               dropped_oldest;
        logic               start_request;
        logic [14:0]        fill_frames;
        logic [31:0]        pushed_total;
        logic [31:0]        rendered_total;
        logic [31:0]        dropped_total;
        logic [31:0]        underrun_total;
    } res_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

// File: rtl/afjb_out_queue.sv
// afjb_out_queue: two-word result queue between the result stage and the output channel.
// Depends on afjb_pkg (res_t).
`default_nettype none

module afjb_out_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire afjb_pkg::res_t in_res,
    output logic               out_valid,
    input  wire logic          out_ready,
    output afjb_pkg::res_t     out_res
);

    afjb_pkg::res_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_res   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_res;
        end
    end

endmodule

`default_nettype wire

// File: rtl/audio_frame_jitter_buffer.sv
// audio_frame_jitter_buffer: drop-oldest ring of audio frames with silence priming,
// zero fill on underrun and saturating totals. Depends on afjb_pkg and afjb_out_queue.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+------------------------------------------
//  s_*      | in  | s_tvalid / s_tready     | s_tuser req_type, s_tdata left/right
//  m_*      | out | m_tvalid / m_tready     | m_tdata samples, flags, fill, totals
//  apb      | in  | psel, penable, pready=1 | capacity, stereo mode, prime count
//
// One word is taken per clock when the output side keeps up: the ring state, the frame
// RAM write and the RAM read all happen at the accepting edge, which also loads the
// result stage and the RAM read data; the word is then offered from the output queue.
// s_tready depends on registers only; the result stage plus a two-word queue absorb
// output stalls, so up to three words may sit inside before s_tready drops.
// Reset clears ring pointers, counts, flags and registers; the frame RAM is not cleared
// (only entries counted as held are ever read back).
`default_nettype none

module audio_frame_jitter_buffer #(
    parameter int BUFFER_FRAMES    = afjb_pkg::BUFFER_FRAMES_DEF,
    parameter int MAX_PRIME_FRAMES = afjb_pkg::MAX_PRIME_FRAMES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input words
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [15:0] in_left, [31:16] in_right
    input  wire logic [1:0]   s_tuser,   // [1:0] req_type
    // result words
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [183:0]      m_tdata,   // [15:0] out_left, [31:16] out_right,
                                         // [32] underrun, [33] dropped_oldest,
                                         // [34] start_request, [49:35] fill_frames,
                                         // [81:50] pushed_total, [113:82] rendered_total,
                                         // [145:114] dropped_total,
                                         // [177:146] underrun_total, [183:178] zero
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // widths that follow from the parameters
    localparam int IDX_W = $clog2(BUFFER_FRAMES);
    localparam int CAP_W = $clog2(BUFFER_FRAMES + 1);
    localparam int SIL_W = (MAX_PRIME_FRAMES > 0) ? $clog2(MAX_PRIME_FRAMES + 1) : 1;
    localparam int PW0   = (CAP_W > 15) ? CAP_W : 15;
    localparam int PW    = (SIL_W > PW0) ? SIL_W : PW0;

    // ---------------- configuration registers ----------------
    logic [14:0] cfg_cap_reg;
    logic        cfg_stereo_reg;
    logic [12:0] cfg_prime_reg;
    logic        cfg_wr;
    logic        cap_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cap_wr = cfg_wr && (paddr[3:2] == afjb_pkg::REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_cap_reg    <= afjb_pkg::CAP_RESET;
            cfg_stereo_reg <= afjb_pkg::STEREO_RESET;
            cfg_prime_reg  <= afjb_pkg::PRIME_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                afjb_pkg::REG_CAPACITY: cfg_cap_reg    <= pwdata[14:0];
                afjb_pkg::REG_STEREO:   cfg_stereo_reg <= pwdata[0];
                afjb_pkg::REG_PRIME:    cfg_prime_reg  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            afjb_pkg::REG_CAPACITY: prdata = {17'd0, cfg_cap_reg};
            afjb_pkg::REG_STEREO:   prdata = {31'd0, cfg_stereo_reg};
            afjb_pkg::REG_PRIME:    prdata = {19'd0, cfg_prime_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // effective capacity: zero acts as one, clipped to the RAM depth
    logic [PW-1:0]    cap_wide;
    logic [CAP_W-1:0] cap;

    assign cap_wide = PW'(cfg_cap_reg);

    always_comb
    begin
        if (cap_wide == '0)
        begin
            cap = CAP_W'(1);
        end
        else if (cap_wide > PW'(BUFFER_FRAMES))
        begin
            cap = CAP_W'(BUFFER_FRAMES);
        end
        else
        begin
            cap = cap_wide[CAP_W-1:0];
        end
    end

    // ---------------- ring state ----------------
    logic [IDX_W-1:0] ri_reg, ri_next;
    logic [IDX_W-1:0] wi_reg, wi_next;
    logic [CAP_W-1:0] fill_reg, fill_next;
    logic [SIL_W-1:0] sil_reg, sil_next;
    logic             primed_reg, primed_next;
    logic             started_reg, started_next;
    logic [31:0]      pushed_reg, pushed_next;
    logic [31:0]      rendered_reg, rendered_next;
    logic [31:0]      dropped_reg, dropped_next;
    logic [31:0]      under_reg, under_next;

    logic             s_fire;
    afjb_pkg::req_t   req;

    assign s_fire = s_tvalid && s_tready;
    assign req    = afjb_pkg::req_t'(s_tuser);

    // pointer wrap and increment modulo capacity
    logic [IDX_W-1:0] ri_w, wi_w, ri_inc, wi_inc;
    logic [CAP_W-1:0] ri_p1, wi_p1;

    assign ri_w   = (CAP_W'(ri_reg) >= cap) ? '0 : ri_reg;
    assign wi_w   = (CAP_W'(wi_reg) >= cap) ? '0 : wi_reg;
    assign ri_p1  = CAP_W'(ri_w) + CAP_W'(1);
    assign wi_p1  = CAP_W'(wi_w) + CAP_W'(1);
    assign ri_inc = (ri_p1 == cap) ? '0 : ri_p1[IDX_W-1:0];
    assign wi_inc = (wi_p1 == cap) ? '0 : wi_p1[IDX_W-1:0];

    // silence to add at priming: prime count capped at the maximum and at free room
    logic [PW-1:0] prime_cap, room, prime_fit;

    always_comb
    begin
        prime_cap = PW'(cfg_prime_reg);
        if (prime_cap > PW'(MAX_PRIME_FRAMES))
        begin
            prime_cap = PW'(MAX_PRIME_FRAMES);
        end
        room      = PW'(cap) - PW'(fill_reg) - PW'(sil_reg);
        prime_fit = (prime_cap > room) ? room : prime_cap;
    end

    // step logic
    logic [SIL_W-1:0] sil_prim;
    logic [CAP_W-1:0] fill_drop;
    logic             f_under, f_drop, f_start, f_mem;
    logic             ram_we, ram_re;
    logic [31:0]      ram_wdata;

    always_comb
    begin
        ri_next       = ri_reg;
        wi_next       = wi_reg;
        fill_next     = fill_reg;
        sil_next      = sil_reg;
        primed_next   = primed_reg;
        started_next  = started_reg;
        pushed_next   = pushed_reg;
        rendered_next = rendered_reg;
        dropped_next  = dropped_reg;
        under_next    = under_reg;
        sil_prim      = sil_reg;
        fill_drop     = fill_reg;
        f_under       = 1'b0;
        f_drop        = 1'b0;
        f_start       = 1'b0;
        f_mem         = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_wdata     = {(cfg_stereo_reg ? s_tdata[31:16] : 16'd0), s_tdata[15:0]};
        case (req)
            afjb_pkg::REQ_PUSH:
            begin
                if (!primed_reg)
                begin
                    sil_prim    = sil_reg + SIL_W'(prime_fit);
                    primed_next = 1'b1;
                end
                sil_next = sil_prim;
                // full: drop silence first, then the oldest stored frame
                if (PW'(fill_reg) + PW'(sil_prim) >= PW'(cap))
                begin
                    f_drop       = 1'b1;
                    dropped_next = afjb_pkg::sat_inc(dropped_reg);
                    if (sil_prim != '0)
                    begin
                        sil_next = sil_prim - SIL_W'(1);
                    end
                    else
                    begin
                        ri_next   = ri_inc;
                        fill_drop = fill_reg - CAP_W'(1);
                    end
                end
                ram_we      = 1'b1;
                wi_next     = wi_inc;
                fill_next   = fill_drop + CAP_W'(1);
                pushed_next = afjb_pkg::sat_inc(pushed_reg);
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    f_start      = 1'b1;
                end
            end
            afjb_pkg::REQ_POP:
            begin
                if (sil_reg != '0)
                begin
                    sil_next      = sil_reg - SIL_W'(1);
                    rendered_next = afjb_pkg::sat_inc(rendered_reg);
                end
                else if (fill_reg != '0)
                begin
                    f_mem         = 1'b1;
                    ram_re        = 1'b1;
                    ri_next       = ri_inc;
                    fill_next     = fill_reg - CAP_W'(1);
                    rendered_next = afjb_pkg::sat_inc(rendered_reg);
                end
                else
                begin
                    f_under    = 1'b1;
                    under_next = afjb_pkg::sat_inc(under_reg);
                end
            end
            afjb_pkg::REQ_RESET:
            begin
                ri_next       = '0;
                wi_next       = '0;
                fill_next     = '0;
                sil_next      = '0;
                primed_next   = 1'b0;
                started_next  = 1'b0;
                pushed_next   = '0;
                rendered_next = '0;
                dropped_next  = '0;
                under_next    = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ri_reg       <= '0;
            wi_reg       <= '0;
            fill_reg     <= '0;
            sil_reg      <= '0;
            primed_reg   <= 1'b0;
            started_reg  <= 1'b0;
            pushed_reg   <= '0;
            rendered_reg <= '0;
            dropped_reg  <= '0;
            under_reg    <= '0;
        end
        else
        begin
            // capacity write empties the ring but keeps flags and totals
            if (cap_wr)
            begin
                ri_reg   <= '0;
                wi_reg   <= '0;
                fill_reg <= '0;
                sil_reg  <= '0;
            end
            else if (s_fire)
            begin
                ri_reg   <= ri_next;
                wi_reg   <= wi_next;
                fill_reg <= fill_next;
                sil_reg  <= sil_next;
            end
            if (s_fire)
            begin
                primed_reg   <= primed_next;
                started_reg  <= started_next;
                pushed_reg   <= pushed_next;
                rendered_reg <= rendered_next;
                dropped_reg  <= dropped_next;
                under_reg    <= under_next;
            end
        end
    end

    // ---------------- frame RAM: one write or one registered read per word ----------------
    logic [31:0] ram [BUFFER_FRAMES];
    logic [31:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (s_fire && ram_we)
        begin
            ram[wi_w] <= ram_wdata;
        end
        if (s_fire && ram_re)
        begin
            rd_reg <= ram[ri_w];
        end
    end

    // ---------------- result stage ----------------
    logic             a_valid_reg;
    logic             a_mem_reg;
    logic             a_stereo_reg;
    logic             a_under_reg;
    logic             a_drop_reg;
    logic             a_start_reg;
    logic [14:0]      a_fill_reg;
    logic [31:0]      a_pushed_reg;
    logic [31:0]      a_rendered_reg;
    logic [31:0]      a_dropped_reg;
    logic [31:0]      a_under_tot_reg;
    logic [PW-1:0]    fill_sum;
    logic             q_in_ready;
    afjb_pkg::res_t   a_res;
    afjb_pkg::res_t   q_res;

    assign fill_sum = PW'(fill_next) + PW'(sil_next);
    assign s_tready = !a_valid_reg || q_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (q_in_ready)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            a_mem_reg       <= f_mem;
            a_stereo_reg    <= cfg_stereo_reg;
            a_under_reg     <= f_under;
            a_drop_reg      <= f_drop;
            a_start_reg     <= f_start;
            a_fill_reg      <= fill_sum[14:0];
            a_pushed_reg    <= pushed_next;
            a_rendered_reg  <= rendered_next;
            a_dropped_reg   <= dropped_next;
            a_under_tot_reg <= under_next;
        end
    end

    always_comb
    begin
        a_res.out_left       = a_mem_reg ? rd_reg[15:0] : 16'sd0;
        a_res.out_right      = (a_mem_reg && a_stereo_reg) ? rd_reg[31:16] : 16'sd0;
        a_res.underrun       = a_under_reg;
        a_res.dropped_oldest = a_drop_reg;
        a_res.start_request  = a_start_reg;
        a_res.fill_frames    = a_fill_reg;
        a_res.pushed_total   = a_pushed_reg;
        a_res.rendered_total = a_rendered_reg;
        a_res.dropped_total  = a_dropped_reg;
        a_res.underrun_total = a_under_tot_reg;
    end

    afjb_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_ready  (q_in_ready),
        .in_res    (a_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (q_res)
    );

    assign m_tdata = {6'd0,
                      q_res.underrun_total,
                      q_res.dropped_total,
                      q_res.rendered_total,
                      q_res.pushed_total,
                      q_res.fill_frames,
                      q_res.start_request,
                      q_res.dropped_oldest,
                      q_res.underrun,
                      q_res.out_right,
                      q_res.out_left};

    // ---------------- assertions ----------------
    // held frames plus pending silence never exceed the capacity in use
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (PW'(fill_reg) + PW'(sil_reg)) <= PW'(cap))
        else $error("ring holds more frames than its capacity");

    // a stream reset leaves ring and totals empty
    a_stream_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (req == afjb_pkg::REQ_RESET) && !cap_wr) |=>
        (fill_reg == '0) && (sil_reg == '0) && (pushed_reg == '0) &&
        (under_reg == '0) && !primed_reg && !started_reg)
        else $error("stream reset did not clear state");

    // a word sits in the result stage in the clock after acceptance
    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> a_valid_reg)
        else $error("accepted word missing from result stage");

    // a result never marks both an underrun and a frame taken from the RAM
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> !(a_mem_reg && a_under_reg))
        else $error("underrun flagged on a stored frame");

endmodule

`default_nettype wire
